>>> design/assert_macros.svh
// Assertion macros used by the queue design.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define KMPQ_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

// Check that an antecedent implies a consequent in the same cycle.
`define KMPQ_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

>>> design/kmpq_pkg.sv
// Package for the keyed max priority queue: sizes, request codes, entry type, ranking.
// No dependencies.
package kmpq_pkg;
	localparam int CAPACITY = 1024;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_RAISE  = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_QUERY  = 2'd3;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  level;
		logic [31:0] seq;
	} entry_t;

	localparam int EW = $bits(entry_t);

	// true when a ranks strictly above b: higher level, then earlier arrival
	function automatic logic ranks_above(entry_t a, entry_t b);
		if (a.level != b.level) begin
			return a.level > b.level;
		end
		return a.seq < b.seq;
	endfunction
endpackage

>>> design/kmpq_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kmpq_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 56
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/keyed_max_priority_queue.sv
// Keyed max priority queue: heap in one RAM, walked by a sequencer.
// Steps: a query strobes done straight from idle on an empty heap, else after QWAIT;
// raise/delete search one slot a cycle, then sift up through UPCHK and UPCMP per level
// and sift down through DNL, DNLW, DNRW (if a right child exists) and DNDEC per level;
// insert only sifts up. One item at a time, bounded by the single RAM read port.
// Reset clears the entry count, arrival counter and sequencer; RAM needs no clear.
// Results are strobed on done for one cycle; the receiver cannot stall them.
`include "assert_macros.svh"
module keyed_max_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] entry_id,
	input  logic [7:0]  amount,
	output logic        done,
	output logic        is_empty,
	output logic [15:0] top_id
);
	import kmpq_pkg::*;

	// sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_QWAIT = 4'd1;
	localparam logic [3:0] ST_SRCH  = 4'd2;
	localparam logic [3:0] ST_DLAST = 4'd3;
	localparam logic [3:0] ST_UPCHK = 4'd4;
	localparam logic [3:0] ST_UPCMP = 4'd5;
	localparam logic [3:0] ST_DNRD  = 4'd6;
	localparam logic [3:0] ST_DNCUR = 4'd7;
	localparam logic [3:0] ST_DNL   = 4'd8;
	localparam logic [3:0] ST_DNLW  = 4'd9;
	localparam logic [3:0] ST_DNRW  = 4'd10;
	localparam logic [3:0] ST_DNDEC = 4'd11;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [31:0]   arr_q;
	logic [1:0]    req_q;
	logic [15:0]   id_q;
	logic [7:0]    amt_q;       // increment held for a raise
	entry_t        cur_q;       // item being sifted; its slot is a hole
	logic [AW-1:0] pos_q;       // current hole
	logic [AW-1:0] orig_q;      // slot freed by a delete
	logic          del_q;       // sift down follows the sift up
	logic [CW-1:0] idx_q;       // next slot to read during search
	logic          sv_s1;
	logic [AW-1:0] sa_s1;
	entry_t        best_q;
	logic          bchild_q;
	logic [AW-1:0] bpos_q;
	logic          done_q;
	logic          empty_q;
	logic [15:0]   top_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t        rd;

	logic          found;
	logic [CW-1:0] last;
	logic [AW-1:0] parent;
	logic [CW-1:0] lchild;
	logic [CW-1:0] rchild;
	logic          up_win;
	logic [8:0]    lvl_sum;

	kmpq_ram #(.ADDR_W(AW), .DATA_W(EW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd      = entry_t'(ram_rdata);
	assign found   = sv_s1 && (rd.id == id_q);
	assign last    = count_q - CW'(1);
	assign parent  = AW'((pos_q - AW'(1)) >> 1);
	assign lchild  = {pos_q, 1'b1};
	assign rchild  = lchild + CW'(1);
	assign up_win  = ranks_above(cur_q, rd);
	assign lvl_sum = {1'b0, rd.level} + {1'b0, amt_q};

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign is_empty = empty_q;
	assign top_id   = top_q;

	// RAM port steering per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		ram_raddr = pos_q;
		case (state_q)
			ST_IDLE:  ram_raddr = '0;
			ST_SRCH: begin
				if (found && req_q == REQ_DELETE) begin
					ram_raddr = last[AW-1:0];
				end else begin
					ram_raddr = idx_q[AW-1:0];
				end
			end
			ST_UPCHK: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = parent;
				end
			end
			ST_UPCMP: begin
				ram_we    = 1'b1;
				ram_wdata = up_win ? rd : cur_q;
			end
			ST_DNRD:  ram_raddr = pos_q;
			ST_DNL: begin
				ram_raddr = lchild[AW-1:0];
				ram_we    = (lchild >= count_q);
			end
			ST_DNLW:  ram_raddr = rchild[AW-1:0];
			ST_DNDEC: begin
				ram_we    = 1'b1;
				ram_wdata = bchild_q ? best_q : cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			arr_q    <= '0;
			sv_s1    <= 1'b0;
			done_q   <= 1'b0;
			del_q    <= 1'b0;
			bchild_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						arr_q <= arr_q + 32'd1;
						req_q <= req_type;
						id_q  <= entry_id;
						amt_q <= amount;
						idx_q <= '0;
						sv_s1 <= 1'b0;
						del_q <= 1'b0;
						case (req_type)
							REQ_INSERT: begin
								// drop the item when the heap is full
								if (count_q < CW'(CAPACITY)) begin
									cur_q   <= '{id: entry_id, level: amount, seq: arr_q};
									pos_q   <= count_q[AW-1:0];
									count_q <= count_q + CW'(1);
									state_q <= ST_UPCHK;
								end
							end
							REQ_RAISE, REQ_DELETE: begin
								if (count_q != '0) begin
									state_q <= ST_SRCH;
								end
							end
							REQ_QUERY: begin
								if (count_q == '0) begin
									done_q  <= 1'b1;
									empty_q <= 1'b1;
									top_q   <= '0;
								end else begin
									state_q <= ST_QWAIT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_QWAIT: begin
					done_q  <= 1'b1;
					empty_q <= 1'b0;
					top_q   <= rd.id;
					state_q <= ST_IDLE;
				end
				ST_SRCH: begin
					// stream slot reads; compare each in the cycle after its read
					if (found) begin
						sv_s1 <= 1'b0;
						pos_q <= sa_s1;
						if (req_q == REQ_RAISE) begin
							cur_q   <= '{id: rd.id,
								level: (lvl_sum[8] ? 8'hFF : lvl_sum[7:0]),
								seq: rd.seq};
							state_q <= ST_UPCHK;
						end else begin
							count_q <= last;
							orig_q  <= sa_s1;
							if ({1'b0, sa_s1} < last) begin
								del_q   <= 1'b1;
								state_q <= ST_DLAST;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						if (idx_q < count_q) begin
							idx_q <= idx_q + CW'(1);
							sv_s1 <= 1'b1;
							sa_s1 <= idx_q[AW-1:0];
						end else begin
							sv_s1 <= 1'b0;
						end
						if (sv_s1 && {1'b0, sa_s1} == last) begin
							// absent id: ignore the item
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DLAST: begin
					cur_q   <= rd;
					state_q <= ST_UPCHK;
				end
				ST_UPCHK: begin
					if (pos_q == '0) begin
						state_q <= del_q ? ST_DNRD : ST_IDLE;
						pos_q   <= orig_q;
					end else begin
						state_q <= ST_UPCMP;
					end
				end
				ST_UPCMP: begin
					if (up_win) begin
						pos_q   <= parent;
						state_q <= ST_UPCHK;
					end else begin
						pos_q   <= orig_q;
						state_q <= del_q ? ST_DNRD : ST_IDLE;
					end
				end
				ST_DNRD:  state_q <= ST_DNCUR;
				ST_DNCUR: begin
					cur_q   <= rd;
					state_q <= ST_DNL;
				end
				ST_DNL: begin
					state_q <= (lchild < count_q) ? ST_DNLW : ST_IDLE;
				end
				ST_DNLW: begin
					if (ranks_above(rd, cur_q)) begin
						best_q   <= rd;
						bchild_q <= 1'b1;
						bpos_q   <= lchild[AW-1:0];
					end else begin
						best_q   <= cur_q;
						bchild_q <= 1'b0;
					end
					state_q <= (rchild < count_q) ? ST_DNRW : ST_DNDEC;
				end
				ST_DNRW: begin
					if (ranks_above(rd, best_q)) begin
						best_q   <= rd;
						bchild_q <= 1'b1;
						bpos_q   <= rchild[AW-1:0];
					end
					state_q <= ST_DNDEC;
				end
				ST_DNDEC: begin
					if (bchild_q) begin
						pos_q   <= bpos_q;
						state_q <= ST_DNL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the entry count never exceeds capacity
	`KMPQ_ALWAYS(a_count_cap, count_q <= CW'(CAPACITY))
	// no RAM write while waiting for an item
	`KMPQ_IMPLIES(a_idle_no_wr, state_q == ST_IDLE, !ram_we)
	// a result follows only a query step
	`KMPQ_IMPLIES(a_done_src, done_q,
		$past(state_q == ST_QWAIT) || ($past(state_q == ST_IDLE) && $past(req_type == REQ_QUERY)))
endmodule
